@@ rtl/core/afsf_pkg.sv @@
// Shared types and constants for the audio frame FIFO with silence fill.
// Item and result beat structs, configuration register codes, saturating add.
// Used by afsf_ctrl, afsf_dp and audio_fifo_overflow_silence_fill_top.
`default_nettype none

package afsf_pkg;

  localparam int IO_LANES    = 4;
  localparam int WORD_W      = 32;
  localparam int LEN_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_FRAMES = 2'd1;

  localparam logic [2:0]       CHANNEL_COUNT_RESET   = 3'd2;
  localparam logic [LEN_W-1:0] CAPACITY_FRAMES_RESET = 13'd4096;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic             command;
    logic             block_start;
    logic [LEN_W-1:0] block_frames;
    logic [WORD_W-1:0] sample_0;
    logic [WORD_W-1:0] sample_1;
    logic [WORD_W-1:0] sample_2;
    logic [WORD_W-1:0] sample_3;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_valid;
    logic              is_silence;
    logic [WORD_W-1:0] out_sample_0;
    logic [WORD_W-1:0] out_sample_1;
    logic [WORD_W-1:0] out_sample_2;
    logic [WORD_W-1:0] out_sample_3;
    logic [WORD_W-1:0] delivered_total;
    logic [WORD_W-1:0] overflow_total;
    logic [WORD_W-1:0] silence_total;
  } result_t;

  typedef struct packed {
    logic exec;  // apply the accepted item to the datapath state
    logic load;  // move the pending result into the output register
  } ctrl_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_PEND
  } state_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/afsf_ctrl.sv @@
// Controller for the audio frame FIFO: tracks one pending result and the
// output register, and issues exec and load commands. Depends on afsf_pkg.
`default_nettype none

module afsf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output afsf_pkg::ctrl_cmd_t     cmd
);

  afsf_pkg::state_t state, state_next;
  logic result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= afsf_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    cmd.load   = 1'b0;
    item_stall = 1'b0;
    unique case (state)
      afsf_pkg::ST_IDLE: begin
        cmd.load = 1'b0;
      end
      afsf_pkg::ST_PEND: begin
        // load when the output register is empty or its beat leaves now
        cmd.load = !result_valid || !result_stall;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
    item_stall = (state == afsf_pkg::ST_PEND) && !cmd.load;
    cmd.exec   = item_valid && !item_stall;

    priority if (cmd.exec) begin
      state_next = afsf_pkg::ST_PEND;
    end else if (cmd.load) begin
      state_next = afsf_pkg::ST_IDLE;
    end else begin
      state_next = state;
    end

    priority if (cmd.load) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/afsf_dp.sv @@
// Datapath for the audio frame FIFO: ring memory, pointers, drop mode,
// silence debt, counters, configuration registers and result registers.
// Depends on afsf_pkg; driven by afsf_ctrl commands.
`default_nettype none

module afsf_dp #(
  parameter int RING_FRAMES  = 4096,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire afsf_pkg::ctrl_cmd_t                  cmd,
  input  wire afsf_pkg::item_t                      item,
  input  wire logic                                 cfg_valid,
  input  wire logic [afsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [afsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output afsf_pkg::result_t                         result
);

  localparam int LANES  = (MAX_CHANNELS < afsf_pkg::IO_LANES) ? MAX_CHANNELS
                                                              : afsf_pkg::IO_LANES;
  localparam int PW     = $clog2(2 * RING_FRAMES);
  localparam int AW     = $clog2(RING_FRAMES);
  localparam int NW     = ((PW > afsf_pkg::LEN_W) ? PW : afsf_pkg::LEN_W) + 1;
  localparam int CHW    = 4;
  localparam int WW     = afsf_pkg::WORD_W;
  localparam int MEM_W  = LANES * SAMPLE_BITS;

  // architectural state
  logic [PW-1:0]  read_pointer, read_pointer_next;
  logic [PW-1:0]  write_pointer, write_pointer_next;
  logic           drop_mode, drop_mode_next;
  logic           block_accepting, block_accepting_next;
  logic [WW-1:0]  pending_silence, pending_silence_next;
  logic [WW-1:0]  delivered_count, delivered_count_next;
  logic [WW-1:0]  overflow_count, overflow_count_next;
  logic [WW-1:0]  silence_count, silence_count_next;
  logic [2:0]     channel_count;
  logic [afsf_pkg::LEN_W-1:0] capacity_frames;

  // ring memory and registered read word
  logic [MEM_W-1:0] ring [RING_FRAMES];
  logic [MEM_W-1:0] rd_word;
  logic [MEM_W-1:0] wr_word;

  // pending result held between exec and load
  logic             pend_acc, pend_valid, pend_sil, pend_use_ram;
  logic [LANES-1:0] pend_lane_en;
  logic [WW-1:0]    pend_delivered, pend_overflow, pend_silence;

  // combinational values for the item at hand
  logic [NW-1:0]    used, cap_eff, free_frames, len_ext;
  logic [CHW-1:0]   ch_eff;
  logic [LANES-1:0] lane_en;
  logic [AW-1:0]    wr_slot, rd_slot;
  logic             store, has_frame, give_silence, acc;
  logic [WW-1:0]    in_samp  [afsf_pkg::IO_LANES];
  logic [WW-1:0]    lane_out [afsf_pkg::IO_LANES];

  assign in_samp[0] = item.sample_0;
  assign in_samp[1] = item.sample_1;
  assign in_samp[2] = item.sample_2;
  assign in_samp[3] = item.sample_3;

  assign wr_slot = (write_pointer >= PW'(RING_FRAMES))
                   ? AW'(write_pointer - PW'(RING_FRAMES)) : AW'(write_pointer);
  assign rd_slot = (read_pointer >= PW'(RING_FRAMES))
                   ? AW'(read_pointer - PW'(RING_FRAMES)) : AW'(read_pointer);

  always_comb begin
    if (write_pointer >= read_pointer) begin
      used = NW'(write_pointer) - NW'(read_pointer);
    end else begin
      used = NW'(write_pointer) + NW'(2 * RING_FRAMES) - NW'(read_pointer);
    end

    cap_eff = NW'(capacity_frames);
    if (cap_eff == '0) begin
      cap_eff = NW'(1);
    end
    if (cap_eff > NW'(RING_FRAMES)) begin
      cap_eff = NW'(RING_FRAMES);
    end
    free_frames = (used >= cap_eff) ? '0 : cap_eff - used;
    len_ext     = NW'(item.block_frames);

    ch_eff = CHW'(channel_count);
    if (ch_eff == '0) begin
      ch_eff = CHW'(1);
    end
    if (ch_eff > CHW'(MAX_CHANNELS)) begin
      ch_eff = CHW'(MAX_CHANNELS);
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_en[i] = CHW'(i) < ch_eff;
    assign wr_word[i*SAMPLE_BITS +: SAMPLE_BITS] = in_samp[i][SAMPLE_BITS-1:0];
  end

  always_comb begin
    read_pointer_next    = read_pointer;
    write_pointer_next   = write_pointer;
    drop_mode_next       = drop_mode;
    block_accepting_next = block_accepting;
    pending_silence_next = pending_silence;
    delivered_count_next = delivered_count;
    overflow_count_next  = overflow_count;
    silence_count_next   = silence_count;
    store        = 1'b0;
    acc          = 1'b0;
    has_frame    = used != '0;
    give_silence = 1'b0;

    if (item.command == afsf_pkg::CMD_PUSH) begin
      has_frame = 1'b0;
      if (item.block_start) begin
        block_accepting_next = 1'b0;
        if (item.block_frames != '0) begin
          if (drop_mode || (len_ext > free_frames)) begin
            // reject the whole block and owe its length as silence
            drop_mode_next       = 1'b1;
            overflow_count_next  = afsf_pkg::sat_add(overflow_count,
                                                     WW'(item.block_frames));
            pending_silence_next = afsf_pkg::sat_add(pending_silence,
                                                     WW'(item.block_frames));
          end else begin
            block_accepting_next = 1'b1;
            store                = 1'b1;
          end
        end
      end else if (block_accepting && (used < NW'(RING_FRAMES))) begin
        store = 1'b1;
      end
    end else begin
      if (has_frame) begin
        read_pointer_next    = (read_pointer == PW'(2 * RING_FRAMES - 1))
                               ? '0 : read_pointer + PW'(1);
        delivered_count_next = afsf_pkg::sat_add(delivered_count, WW'(1));
      end else if (drop_mode && (pending_silence != '0)) begin
        give_silence         = 1'b1;
        pending_silence_next = pending_silence - WW'(1);
        if (pending_silence == WW'(1)) begin
          drop_mode_next = 1'b0;
        end
        delivered_count_next = afsf_pkg::sat_add(delivered_count, WW'(1));
        silence_count_next   = afsf_pkg::sat_add(silence_count, WW'(1));
      end
    end

    if (store) begin
      acc                = 1'b1;
      write_pointer_next = (write_pointer == PW'(2 * RING_FRAMES - 1))
                           ? '0 : write_pointer + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer    <= '0;
      write_pointer   <= '0;
      drop_mode       <= 1'b0;
      block_accepting <= 1'b0;
      pending_silence <= '0;
      delivered_count <= '0;
      overflow_count  <= '0;
      silence_count   <= '0;
      channel_count   <= afsf_pkg::CHANNEL_COUNT_RESET;
      capacity_frames <= afsf_pkg::CAPACITY_FRAMES_RESET;
    end else begin
      if (cmd.exec) begin
        read_pointer    <= read_pointer_next;
        write_pointer   <= write_pointer_next;
        drop_mode       <= drop_mode_next;
        block_accepting <= block_accepting_next;
        pending_silence <= pending_silence_next;
        delivered_count <= delivered_count_next;
        overflow_count  <= overflow_count_next;
        silence_count   <= silence_count_next;
      end
      if (cfg_valid) begin
        if (cfg_index == afsf_pkg::CFG_CHANNEL_COUNT) begin
          channel_count <= cfg_data[2:0];
        end else if (cfg_index == afsf_pkg::CFG_CAPACITY_FRAMES) begin
          capacity_frames <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && store) begin
      ring[wr_slot] <= wr_word;
    end
    if (cmd.exec) begin
      rd_word <= ring[rd_slot];
    end
  end

  // hold the outcome of the accepted item until the output register is free
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_acc       <= acc;
      pend_valid     <= has_frame || give_silence;
      pend_sil       <= give_silence;
      pend_use_ram   <= has_frame;
      pend_lane_en   <= lane_en;
      pend_delivered <= delivered_count_next;
      pend_overflow  <= overflow_count_next;
      pend_silence   <= silence_count_next;
    end
  end

  for (genvar i = 0; i < afsf_pkg::IO_LANES; i++) begin : g_out
    if (i < LANES) begin : g_live
      assign lane_out[i] = (pend_use_ram && pend_lane_en[i])
                           ? WW'(rd_word[i*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
    end else begin : g_dead
      assign lane_out[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.accepted        <= pend_acc;
      result.frame_valid     <= pend_valid;
      result.is_silence      <= pend_sil;
      result.out_sample_0    <= lane_out[0];
      result.out_sample_1    <= lane_out[1];
      result.out_sample_2    <= lane_out[2];
      result.out_sample_3    <= lane_out[3];
      result.delivered_total <= pend_delivered;
      result.overflow_total  <= pend_overflow;
      result.silence_total   <= pend_silence;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/audio_fifo_overflow_silence_fill_top.sv @@
// Audio frame FIFO with block admission and silence fill for dropped blocks.
// An item's result is held in the pending stage, then registered at the output.
// Throughput: one item per cycle while results drain; set by the pending result
// stage in front of the ring's registered read port and the output register.
// Reset (synchronous): pointers, drop mode, debt, counters and config return to
// defaults at once; ring contents are not cleared and take no clearing pass.
`default_nettype none

module audio_fifo_overflow_silence_fill_top #(
  parameter int RING_FRAMES  = 4096,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire afsf_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output afsf_pkg::result_t                     result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [afsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [afsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  afsf_pkg::ctrl_cmd_t cmd;

  // config writes never wait
  assign cfg_ready = 1'b1;

  afsf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  afsf_dp #(
    .RING_FRAMES  (RING_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for audio_fifo_overflow_silence_fill_top: a directed table, then random block
// and pop traffic, each result beat checked against a pinned value or the FIFO predictor.
// Needs afsf_pkg and the RTL top level; reads nothing from disk.
module tb_top;
  import afsf_pkg::*;

  localparam int RING_FRAMES   = 4096;
  localparam int MAX_CHANNELS  = 4;
  localparam int SAMPLE_BITS   = 32;
  localparam int PTR_SPAN      = 2 * RING_FRAMES;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 155;
  localparam int SMALL_CAP_ROW = 10;

  typedef struct {
    item_t   frame;
    bit      pinned;
    result_t want;
  } step_row_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // FIFO predictor state and its copy of the registers
  logic [IO_LANES-1:0][WORD_W-1:0] ring_copy [RING_FRAMES];
  int unsigned rd_ptr       = 0;
  int unsigned wr_ptr       = 0;
  bit          dropping     = 1'b0;
  bit          block_open   = 1'b0;
  logic [31:0] silence_debt = '0;
  logic [31:0] dlv_cnt      = '0;
  logic [31:0] ovf_cnt      = '0;
  logic [31:0] sil_cnt      = '0;
  logic [2:0]  lane_cfg     = CHANNEL_COUNT_RESET;
  logic [12:0] cap_cfg      = CAPACITY_FRAMES_RESET;

  result_t     expected_beats [$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;

  audio_fifo_overflow_silence_fill_top #(
    .RING_FRAMES  (RING_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    longint unsigned total;
    total = longint'(a) + longint'(b);
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic int unsigned queued_frames();
    return (wr_ptr + PTR_SPAN - rd_ptr) % PTR_SPAN;
  endfunction

  function automatic result_t predict_fifo_beat(input item_t f);
    result_t     r;
    int unsigned used, room, cap, lanes, slot;
    r = '0;
    used = queued_frames();
    if (f.command == CMD_PUSH) begin
      if (f.block_start) begin
        cap = (cap_cfg == 0) ? 1 : (cap_cfg > RING_FRAMES) ? RING_FRAMES : cap_cfg;
        room = (used >= cap) ? 0 : cap - used;
        block_open = 1'b0;
        if (f.block_frames != 0) begin
          if (dropping || f.block_frames > room) begin
            // reject the whole block and owe its length as silence
            dropping = 1'b1;
            ovf_cnt = sat_sum(ovf_cnt, 32'(f.block_frames));
            silence_debt = sat_sum(silence_debt, 32'(f.block_frames));
          end else begin
            block_open = 1'b1;
            r.accepted = 1'b1;
          end
        end
      end else if (block_open && used < RING_FRAMES) begin
        r.accepted = 1'b1;
      end
      if (r.accepted) begin
        ring_copy[wr_ptr % RING_FRAMES] = {f.sample_3, f.sample_2, f.sample_1, f.sample_0};
        wr_ptr = (wr_ptr + 1) % PTR_SPAN;
      end
    end else if (used != 0) begin
      slot = rd_ptr % RING_FRAMES;
      lanes = (lane_cfg == 0) ? 1 : (lane_cfg > MAX_CHANNELS) ? MAX_CHANNELS : lane_cfg;
      r.out_sample_0 = ring_copy[slot][0];
      r.out_sample_1 = (lanes > 1) ? ring_copy[slot][1] : '0;
      r.out_sample_2 = (lanes > 2) ? ring_copy[slot][2] : '0;
      r.out_sample_3 = (lanes > 3) ? ring_copy[slot][3] : '0;
      rd_ptr = (rd_ptr + 1) % PTR_SPAN;
      r.frame_valid = 1'b1;
      dlv_cnt = sat_sum(dlv_cnt, 32'd1);
    end else if (dropping && silence_debt != 0) begin
      silence_debt = silence_debt - 32'd1;
      if (silence_debt == 0) dropping = 1'b0;
      r.frame_valid = 1'b1;
      r.is_silence = 1'b1;
      dlv_cnt = sat_sum(dlv_cnt, 32'd1);
      sil_cnt = sat_sum(sil_cnt, 32'd1);
    end
    r.delivered_total = dlv_cnt;
    r.overflow_total = ovf_cnt;
    r.silence_total = sil_cnt;
    return r;
  endfunction

  function automatic item_t rand_frame(input logic cmd, input logic start,
                                       input logic [12:0] len);
    item_t f;
    f.command = cmd;
    f.block_start = start;
    f.block_frames = len;
    f.sample_0 = $urandom;
    f.sample_1 = $urandom;
    f.sample_2 = $urandom;
    f.sample_3 = $urandom;
    return f;
  endfunction

  function automatic step_row_t row(input logic cmd, input logic start, input logic [12:0] len,
                                    input logic [31:0] word, input bit pinned,
                                    input result_t want);
    step_row_t s;
    s.frame = '{command: cmd, block_start: start, block_frames: len,
                sample_0: word, sample_1: word, sample_2: word, sample_3: word};
    s.pinned = pinned;
    s.want = want;
    return s;
  endfunction

  // lanes 2 and 3 read as zero at the reset channel count
  function automatic result_t known(input logic acc, input logic fv, input logic sil,
                                    input logic [31:0] lo_lanes, input logic [31:0] dlv,
                                    input logic [31:0] ovf, input logic [31:0] silt);
    result_t r;
    r = '0;
    r.accepted = acc;
    r.frame_valid = fv;
    r.is_silence = sil;
    r.out_sample_0 = lo_lanes;
    r.out_sample_1 = lo_lanes;
    r.delivered_total = dlv;
    r.overflow_total = ovf;
    r.silence_total = silt;
    return r;
  endfunction

  task automatic send_frame(input item_t f, input bit pinned, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= f;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = predict_fifo_beat(f);
    expected_beats.push_back(pinned ? want : predicted);
    sent_items++;
  endtask

  task automatic send_plain(input item_t f);
    send_frame(f, 1'b0, '0);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic set_idling(input int unsigned mode);
    send_idle_pct = (mode == 1) ? 86 : (mode == 3) ? 29 : 0;
    stall_pct     = (mode == 2) ? 86 : (mode == 3) ? 29 : 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CHANNEL_COUNT) lane_cfg = val[2:0];
    else cap_cfg = val;
  endtask

  task automatic set_config(input logic [2:0] lanes, input logic [12:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    // upper data bits are don't-care for the channel count
    write_reg(CFG_CHANNEL_COUNT, {10'($urandom), lanes});
    write_reg(CFG_CAPACITY_FRAMES, cap);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned mode);
    int unsigned pick, len, n, base;
    bit          paused;
    logic        start;
    set_idling(mode);
    base = sent_items;
    paused = 1'b0;
    while (sent_items - base < PHASE_ITEMS) begin
      if (!paused && sent_items - base >= PHASE_ITEMS / 2) begin
        // hold the sender until the pipeline has emptied
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(48, 1) : $urandom_range(10, 1);
        n = len;
        case ($urandom_range(9))
          0: n = len + $urandom_range(3, 1);
          1: n = $urandom_range(len, 1);
          default: n = len;
        endcase
        send_plain(rand_frame(CMD_PUSH, 1'b1, 13'(len)));
        repeat (n - 1) send_plain(rand_frame(CMD_PUSH, 1'b0, 13'($urandom)));
      end else if (pick < 85) begin
        repeat ($urandom_range(16, 1))
          send_plain(rand_frame(CMD_POP, 1'($urandom), 13'($urandom)));
      end else if (pick < 95) begin
        start = ($urandom_range(3) == 0);
        send_plain(rand_frame(1'($urandom), start,
                              start ? 13'($urandom_range(24)) : 13'($urandom)));
      end else begin
        send_plain(rand_frame(CMD_PUSH, 1'b1, '0));
        send_plain(rand_frame(CMD_PUSH, 1'b0, 13'($urandom)));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_side
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          want = expected_beats.pop_front();
          check_field("accepted", want.accepted, result.accepted);
          check_field("frame_valid", want.frame_valid, result.frame_valid);
          check_field("is_silence", want.is_silence, result.is_silence);
          check_field("out_sample_0", want.out_sample_0, result.out_sample_0);
          check_field("out_sample_1", want.out_sample_1, result.out_sample_1);
          check_field("out_sample_2", want.out_sample_2, result.out_sample_2);
          check_field("out_sample_3", want.out_sample_3, result.out_sample_3);
          check_field("delivered_total", want.delivered_total, result.delivered_total);
          check_field("overflow_total", want.overflow_total, result.overflow_total);
          check_field("silence_total", want.silence_total, result.silence_total);
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    step_row_t   script [$];
    logic [2:0]  lane_plan [8] = '{3'd1, 3'd4, 3'd7, 3'd0, 3'd3, 3'd2, 3'd4, 3'd5};
    logic [12:0] cap_plan [8]  = '{13'd16, 13'd8, 13'd4095, 13'd0,
                                   13'd33, 13'd4096, 13'd1, 13'd8191};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset registers: two channels, full capacity
    script.push_back(row(CMD_POP, 1'b0, 13'd0, '0, 1'b1, known(0, 0, 0, '0, 0, 0, 0)));
    script.push_back(row(CMD_PUSH, 1'b1, 13'd0, 32'h1234_5678, 1'b1,
                         known(0, 0, 0, '0, 0, 0, 0)));
    script.push_back(row(CMD_PUSH, 1'b0, 13'd8191, '1, 1'b1, known(0, 0, 0, '0, 0, 0, 0)));
    script.push_back(row(CMD_PUSH, 1'b1, 13'd1, '1, 1'b1, known(1, 0, 0, '0, 0, 0, 0)));
    script.push_back(row(CMD_PUSH, 1'b0, 13'd0, '0, 1'b0, '0));
    script.push_back(row(CMD_PUSH, 1'b0, 13'd4096, 32'hA5A5_5A5A, 1'b0, '0));
    script.push_back(row(CMD_POP, 1'b1, 13'd8191, '0, 1'b1, known(0, 1, 0, '1, 1, 0, 0)));
    script.push_back(row(CMD_POP, 1'b0, 13'd0, '1, 1'b0, '0));
    script.push_back(row(CMD_POP, 1'b0, 13'd0, '0, 1'b0, '0));
    script.push_back(row(CMD_POP, 1'b0, 13'd0, '0, 1'b0, '0));
    // two channels, capacity of four frames from here on
    script.push_back(row(CMD_PUSH, 1'b1, 13'd5, '1, 1'b1,
                         known(0, 0, 0, '0, 3, 5, 0)));
    script.push_back(row(CMD_PUSH, 1'b0, 13'd5, 32'h0F0F_F0F0, 1'b0, '0));
    script.push_back(row(CMD_PUSH, 1'b1, 13'd1, 32'h8000_0001, 1'b0, '0));
    script.push_back(row(CMD_POP, 1'b0, 13'd0, '1, 1'b1, known(0, 1, 1, '0, 4, 6, 1)));
    script.push_back(row(CMD_PUSH, 1'b1, 13'd2, 32'h7FFF_FFFF, 1'b0, '0));
    foreach (script[i]) begin
      if (i == SMALL_CAP_ROW) set_config(3'd2, 13'd4);
      send_frame(script[i].frame, script[i].pinned, script[i].want);
    end

    // pay off the silence debt; the last silent beat leaves drop mode
    while (silence_debt != 0) send_plain(rand_frame(CMD_POP, 1'($urandom), 13'($urandom)));
    send_plain(rand_frame(CMD_POP, 1'b0, '0));

    // run an overlong block past capacity, get the next block refused, then drain
    set_config(3'd4, 13'd16);
    set_idling(3);
    send_plain(rand_frame(CMD_PUSH, 1'b1, 13'd16));
    repeat (19) send_plain(rand_frame(CMD_PUSH, 1'b0, 13'($urandom)));
    send_plain(rand_frame(CMD_PUSH, 1'b1, 13'd1));
    repeat (21) send_plain(rand_frame(CMD_POP, 1'($urandom), 13'($urandom)));

    for (int p = 0; p < 8; p++) begin
      set_config(lane_plan[p], cap_plan[p]);
      random_phase(p % 4);
    end

    // longest block length the field can carry
    send_plain(rand_frame(CMD_PUSH, 1'b1, 13'd8191));

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ audio_fifo_overflow_silence_fill_top.f @@
rtl/core/afsf_pkg.sv
rtl/core/afsf_ctrl.sv
rtl/core/afsf_dp.sv
rtl/core/audio_fifo_overflow_silence_fill_top.sv
tb/sv/tb_top.sv
